>>> design/osc_pkg.sv
// ============================================================================
// osc_pkg
// Shared types and constants for the occupation string converter: field
// widths, the action code and the reset value of the orbital count.
// ============================================================================
package osc_pkg;

    // Widths of the fields on the item and result channels and of the configuration word
    localparam int FIELD_W = 64;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 7;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CFG_W-1:0]   cfg_t;

    // Conversion direction carried by each item
    typedef enum logic
    {
        ACT_SPLIT = 1'b0,
        ACT_MERGE = 1'b1
    } action_t;

    // Orbital count after reset
    localparam cfg_t NUM_ORBITALS_RST = 7'd64;

endpackage

>>> design/osc_if.sv
// ============================================================================
// osc_if
// Valid/ready channels of the occupation string converter: one for the
// occupation items going in and one for the converted results coming out.
// ============================================================================

// Item channel: one occupation string per transfer
interface osc_in_if;
    logic              valid;
    logic              ready;
    osc_pkg::action_t  action;
    osc_pkg::field_t   alpha_bits;
    osc_pkg::field_t   beta_bits;
    osc_pkg::field_t   double_bits;
    osc_pkg::field_t   single_bits;
    osc_pkg::field_t   spin_bits;
    logic              last_string;

    modport source
    (
        output valid, action, alpha_bits, beta_bits, double_bits,
               single_bits, spin_bits, last_string,
        input  ready
    );

    modport sink
    (
        input  valid, action, alpha_bits, beta_bits, double_bits,
               single_bits, spin_bits, last_string,
        output ready
    );
endinterface

// Result channel: one converted string per transfer
interface osc_out_if;
    logic             valid;
    logic             ready;
    osc_pkg::count_t  pair_count;
    osc_pkg::field_t  double_mask;
    osc_pkg::field_t  single_mask;
    osc_pkg::field_t  spin_mask;
    osc_pkg::field_t  alpha_out;
    osc_pkg::field_t  beta_out;
    logic             last_out;

    modport source
    (
        output valid, pair_count, double_mask, single_mask, spin_mask,
               alpha_out, beta_out, last_out,
        input  ready
    );

    modport sink
    (
        input  valid, pair_count, double_mask, single_mask, spin_mask,
               alpha_out, beta_out, last_out,
        output ready
    );
endinterface

>>> design/occupation_string_converter.sv
// ============================================================================
// occupation_string_converter
// Splits alpha/beta occupation strings into double, singles and spin masks,
// or merges those masks back into alpha/beta strings, one item per transfer.
// ============================================================================
// An item passes the stage registers in order before its result is valid.
// Throughput: one item per cycle unless result.ready stalls; four pipeline stages (input capture, prefix
// counts, compaction select, spin select / output) each hold one item.
// Ready is combinational from result.ready back through the stage flags.
// Reset: all stage valid flags clear, the active orbital mask selects all orbitals.
module occupation_string_converter #(
    parameter int ORBITAL_BITS = 64
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  osc_pkg::cfg_t     cfg_wr_data,
    osc_in_if.sink            item,
    osc_out_if.source         result
);

    localparam int IDX_W = $clog2(ORBITAL_BITS);
    localparam int CNT_W = $clog2(ORBITAL_BITS + 1);
    localparam int FW    = osc_pkg::FIELD_W;
    localparam int PW    = osc_pkg::COUNT_W;
    localparam int CW    = osc_pkg::CFG_W;

    typedef logic [ORBITAL_BITS-1:0] orb_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef cnt_t                    cnt_arr_t [ORBITAL_BITS];
    typedef idx_t                    idx_arr_t [ORBITAL_BITS];

    // Inclusive prefix population count, log-depth parallel prefix
    function automatic cnt_arr_t prefix_incl(input orb_t v);
        cnt_arr_t acc;
        cnt_arr_t nxt;
        for (int i = 0; i < ORBITAL_BITS; i++)
        begin
            acc[i] = CNT_W'(v[i]);
        end
        for (int d = 1; d < ORBITAL_BITS; d = d * 2)
        begin
            for (int i = 0; i < ORBITAL_BITS; i++)
            begin
                if (i >= d)
                begin
                    nxt[i] = CNT_W'(acc[i] + acc[i-d]);
                end
                else
                begin
                    nxt[i] = acc[i];
                end
            end
            acc = nxt;
        end
        return acc;
    endfunction

    // Exclusive prefix count: number of set bits below each position
    function automatic cnt_arr_t prefix_excl(input orb_t v);
        return prefix_incl({v[ORBITAL_BITS-2:0], 1'b0});
    endfunction

    // ------------------------------------------------------------------
    // Active orbital mask, rebuilt on each configuration write
    // ------------------------------------------------------------------
    orb_t act_mask_reg;
    orb_t act_mask_next;

    always_comb
    begin
        for (int k = 0; k < ORBITAL_BITS; k++)
        begin
            act_mask_next[k] = (CW'(k) < cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_mask_reg <= '1;
        end
        else if (cfg_wr_en)
        begin
            act_mask_reg <= act_mask_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or drains this cycle
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign item.ready   = rdy1;
    assign result.valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= item.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the item, drop inactive orbitals of positional inputs
    // ------------------------------------------------------------------
    logic s1_merge_reg, s1_last_reg;
    orb_t s1_a_reg, s1_b_reg, s1_d_reg, s1_s_reg, s1_p_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_merge_reg <= (item.action == osc_pkg::ACT_MERGE);
            s1_last_reg  <= item.last_string;
            s1_a_reg     <= item.alpha_bits[ORBITAL_BITS-1:0] & act_mask_reg;
            s1_b_reg     <= item.beta_bits[ORBITAL_BITS-1:0] & act_mask_reg;
            s1_d_reg     <= item.double_bits[ORBITAL_BITS-1:0] & act_mask_reg;
            s1_s_reg     <= item.single_bits[ORBITAL_BITS-1:0];
            s1_p_reg     <= item.spin_bits[ORBITAL_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: classify orbitals and form prefix counts
    // ------------------------------------------------------------------
    orb_t     s2_dbl_next, s2_nd_next, s2_occ_next;
    cnt_arr_t s2_cnta_next, s2_cntb_next, s2_dblcnt;

    always_comb
    begin
        if (s1_merge_reg)
        begin
            s2_dbl_next = s1_d_reg;
            s2_occ_next = '0;
        end
        else
        begin
            s2_dbl_next = s1_a_reg & s1_b_reg;
            s2_occ_next = (s1_a_reg | s1_b_reg) & ~s2_dbl_next;
        end
        s2_nd_next   = act_mask_reg & ~s2_dbl_next;
        s2_cnta_next = prefix_excl(s2_nd_next);
        s2_cntb_next = prefix_excl(s1_merge_reg ? s1_s_reg : s2_occ_next);
        s2_dblcnt    = prefix_incl(s2_dbl_next);
    end

    logic     s2_merge_reg, s2_last_reg;
    orb_t     s2_dbl_reg, s2_nd_reg, s2_occ_reg, s2_a_reg, s2_s_reg, s2_p_reg;
    cnt_arr_t s2_cnta_reg, s2_cntb_reg;
    cnt_t     s2_pairs_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_merge_reg <= s1_merge_reg;
            s2_last_reg  <= s1_last_reg;
            s2_dbl_reg   <= s2_dbl_next;
            s2_nd_reg    <= s2_nd_next;
            s2_occ_reg   <= s2_occ_next;
            s2_a_reg     <= s1_a_reg;
            s2_s_reg     <= s1_s_reg;
            s2_p_reg     <= s1_p_reg;
            s2_cnta_reg  <= s2_cnta_next;
            s2_cntb_reg  <= s2_cntb_next;
            s2_pairs_reg <= s2_dblcnt[ORBITAL_BITS-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compact in split mode, expand singles in merge mode
    // ------------------------------------------------------------------
    orb_t     s3_smask_next, s3_pmask_next, s3_occm_next;
    idx_arr_t s3_spi_next;

    always_comb
    begin
        // Compaction: each output bit gathers the orbital whose rank matches
        for (int j = 0; j < ORBITAL_BITS; j++)
        begin
            s3_smask_next[j] = 1'b0;
            s3_pmask_next[j] = 1'b0;
            for (int k = 0; k < ORBITAL_BITS; k++)
            begin
                if (s2_occ_reg[k] && (s2_cnta_reg[k] == CNT_W'(j)))
                begin
                    s3_smask_next[j] = 1'b1;
                end
                if (s2_occ_reg[k] && s2_a_reg[k] && (s2_cntb_reg[k] == CNT_W'(j)))
                begin
                    s3_pmask_next[j] = 1'b1;
                end
            end
        end
        // Expansion: look up the singles flag and its electron rank by position
        for (int k = 0; k < ORBITAL_BITS; k++)
        begin
            s3_occm_next[k] = s2_nd_reg[k] & s2_s_reg[s2_cnta_reg[k][IDX_W-1:0]];
            s3_spi_next[k]  = s2_cntb_reg[s2_cnta_reg[k][IDX_W-1:0]][IDX_W-1:0];
        end
    end

    logic     s3_merge_reg, s3_last_reg;
    orb_t     s3_dbl_reg, s3_smask_reg, s3_pmask_reg, s3_occm_reg, s3_p_reg;
    idx_arr_t s3_spi_reg;
    cnt_t     s3_pairs_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_merge_reg <= s2_merge_reg;
            s3_last_reg  <= s2_last_reg;
            s3_dbl_reg   <= s2_dbl_reg;
            s3_smask_reg <= s3_smask_next;
            s3_pmask_reg <= s3_pmask_next;
            s3_occm_reg  <= s3_occm_next;
            s3_p_reg     <= s2_p_reg;
            s3_spi_reg   <= s3_spi_next;
            s3_pairs_reg <= s2_pairs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick spins, zero the unused direction, hold the result
    // ------------------------------------------------------------------
    orb_t             s4_pick;
    osc_pkg::count_t  pair_next;
    osc_pkg::field_t  dmask_next, smask_next, pmask_next, aout_next, bout_next;

    always_comb
    begin
        for (int k = 0; k < ORBITAL_BITS; k++)
        begin
            s4_pick[k] = s3_p_reg[s3_spi_reg[k]];
        end
        if (s3_merge_reg)
        begin
            pair_next  = '0;
            dmask_next = '0;
            smask_next = '0;
            pmask_next = '0;
            aout_next  = FW'(s3_dbl_reg | (s3_occm_reg & s4_pick));
            bout_next  = FW'(s3_dbl_reg | (s3_occm_reg & ~s4_pick));
        end
        else
        begin
            pair_next  = PW'(s3_pairs_reg);
            dmask_next = FW'(s3_dbl_reg);
            smask_next = FW'(s3_smask_reg);
            pmask_next = FW'(s3_pmask_reg);
            aout_next  = '0;
            bout_next  = '0;
        end
    end

    osc_pkg::count_t  pair_reg;
    osc_pkg::field_t  dmask_reg, smask_reg, pmask_reg, aout_reg, bout_reg;
    logic             last_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            pair_reg  <= pair_next;
            dmask_reg <= dmask_next;
            smask_reg <= smask_next;
            pmask_reg <= pmask_next;
            aout_reg  <= aout_next;
            bout_reg  <= bout_next;
            last_reg  <= s3_last_reg;
        end
    end

    assign result.pair_count  = pair_reg;
    assign result.double_mask = dmask_reg;
    assign result.single_mask = smask_reg;
    assign result.spin_mask   = pmask_reg;
    assign result.alpha_out   = aout_reg;
    assign result.beta_out    = bout_reg;
    assign result.last_out    = last_reg;

endmodule

>>> design/osc_checker.sv
// ============================================================================
// osc_port_checker
// Port-level checks for the occupation string converter, bound to the top.
// ============================================================================
module osc_port_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input osc_pkg::count_t  pair_count,
    input osc_pkg::field_t  double_mask,
    input osc_pkg::field_t  single_mask,
    input osc_pkg::field_t  spin_mask,
    input osc_pkg::field_t  alpha_out,
    input osc_pkg::field_t  beta_out,
    input logic             last_out
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(pair_count) && $stable(double_mask) && $stable(single_mask)
            && $stable(spin_mask) && $stable(alpha_out) && $stable(beta_out)
            && $stable(last_out))
        else $error("stalled result changed");

    // Accept an item whenever the output stage is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input blocked while output stage empty");

    // Pair count matches the double mask
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pair_count == $countones(double_mask)))
        else $error("pair count disagrees with double mask");

    // Leave the unused direction at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((alpha_out == '0) && (beta_out == '0))
            || ((pair_count == '0) && (double_mask == '0)
                && (single_mask == '0) && (spin_mask == '0)))
        else $error("both directions carry data");

endmodule

bind occupation_string_converter osc_port_checker u_osc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .pair_count   (result.pair_count),
    .double_mask  (result.double_mask),
    .single_mask  (result.single_mask),
    .spin_mask    (result.spin_mask),
    .alpha_out    (result.alpha_out),
    .beta_out     (result.beta_out),
    .last_out     (result.last_out)
);
